/* src/mcp_pkg.sv */
// Shared types and constants for the motor current PID / PWM block.
// Microword layout, datapath opcodes and fixed-point constants.
// No dependencies.
package mcp_pkg;

	localparam int ERR_W   = 17;
	localparam int SUM_W   = 32;
	localparam int DIFF_W  = 18;
	localparam int FF_W    = 25;
	localparam int ACC_W   = 45;
	localparam int MA_W    = 29;
	localparam int MB_W    = 33;
	localparam int PROD_W  = MA_W + MB_W;
	localparam int LIM_W   = 23;
	localparam int GAIN_W  = 24;
	localparam int PER_W   = 20;
	localparam int X_W     = 27;
	localparam int Q_W     = 20;
	localparam int R_W     = 8;
	localparam int STEP_W  = 4;
	localparam int CIDX_W  = 3;
	localparam int CDATA_W = 24;

	localparam logic [LIM_W-1:0] FULL_DUTY = 23'd6553600;
	// floor(2^34 / 100); quotient off by at most one, fixed by one correction step
	localparam logic [27:0]      RECIP_100 = 28'd171798691;
	localparam int               RECIP_SH  = 34;
	localparam logic [X_W-1:0]   DIVISOR   = 27'd100;

	typedef enum logic [CIDX_W-1:0] {
		REG_KP     = 3'd0,
		REG_KI     = 3'd1,
		REG_KD     = 3'd2,
		REG_ILIMIT = 3'd3,
		REG_OLIMIT = 3'd4,
		REG_PERIOD = 3'd5
	} reg_idx_t;

	typedef enum logic [2:0] {
		MUL_NONE,
		MUL_KP_ERR,
		MUL_KI_SUM,
		MUL_KD_DIFF,
		MUL_MAG_PER,
		MUL_RCP_X
	} mul_sel_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_LOAD,
		OP_INTEG,
		OP_ACC_FF,
		OP_ADD_PROD,
		OP_ADD_ICLAMP,
		OP_CLAMP_U,
		OP_MAG,
		OP_SHIFT,
		OP_QUOT,
		OP_REM,
		OP_INC,
		OP_EMIT
	} op_t;

	typedef enum logic [1:0] {
		C_NEVER,
		C_NO_IN,
		C_REM_LT,
		C_OUT_BUSY
	} cond_t;

	typedef struct packed {
		mul_sel_t          mul;
		op_t               op;
		cond_t             cond;
		logic [STEP_W-1:0] target;
	} uword_t;

	typedef struct packed {
		mul_sel_t mul;
		op_t      op;
		logic     en;
	} ctl_t;

	typedef struct packed {
		logic in_valid;
		logic out_busy;
		logic rem_lt;
	} seq_stat_t;

endpackage

/* src/mcp_sequencer.sv */
// Microprogram ROM and step counter for the PID / PWM block.
// Depends on mcp_pkg for the microword and control types.
module mcp_sequencer (
	input  logic               clk,
	input  logic               arst_n,
	input  mcp_pkg::seq_stat_t stat,
	output mcp_pkg::ctl_t      ctl
);
	import mcp_pkg::*;

	function automatic uword_t rom(input logic [STEP_W-1:0] s);
		uword_t w;
		w = '{mul: MUL_NONE, op: OP_NOP, cond: C_NEVER, target: '0};
		unique case (s)
			4'd0:  begin w.op = OP_LOAD; w.cond = C_NO_IN; w.target = 4'd0; end
			4'd1:  begin w.op = OP_INTEG; end
			4'd2:  begin w.op = OP_ACC_FF; w.mul = MUL_KP_ERR; end
			4'd3:  begin w.op = OP_ADD_PROD; w.mul = MUL_KI_SUM; end
			4'd4:  begin w.op = OP_ADD_ICLAMP; w.mul = MUL_KD_DIFF; end
			4'd5:  begin w.op = OP_ADD_PROD; end
			4'd6:  begin w.op = OP_CLAMP_U; end
			4'd7:  begin w.op = OP_MAG; end
			4'd8:  begin w.mul = MUL_MAG_PER; end
			4'd9:  begin w.op = OP_SHIFT; end
			4'd10: begin w.mul = MUL_RCP_X; end
			4'd11: begin w.op = OP_QUOT; end
			4'd12: begin w.op = OP_REM; end
			4'd13: begin w.cond = C_REM_LT; w.target = 4'd15; end
			4'd14: begin w.op = OP_INC; end
			4'd15: begin w.op = OP_EMIT; w.cond = C_OUT_BUSY; w.target = 4'd15; end
		endcase
		return w;
	endfunction

	logic [STEP_W-1:0] step_q;
	uword_t            uw;
	logic              jump;

	assign uw = rom(step_q);

	always_comb begin
		unique case (uw.cond)
			C_NEVER:    jump = 1'b0;
			C_NO_IN:    jump = !stat.in_valid;
			C_REM_LT:   jump = stat.rem_lt;
			C_OUT_BUSY: jump = stat.out_busy;
			default:    jump = 1'b0;
		endcase
	end

	assign ctl = '{mul: uw.mul, op: uw.op, en: !jump};

	// last step wraps to step 0
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else begin
			step_q <= jump ? uw.target : step_q + 1'b1;
		end
	end

endmodule

/* src/mcp_datapath.sv */
// Datapath of the PID / PWM block: shared multiplier, accumulator,
// controller state and result registers, steered by the microword.
// Depends on mcp_pkg.
module mcp_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  mcp_pkg::ctl_t                       ctl,
	input  logic signed [15:0]                  reference_ma,
	input  logic signed [15:0]                  measured_ma,
	input  logic                                accel_positive,
	input  logic signed [23:0]                  feedforward,
	input  logic [mcp_pkg::GAIN_W-1:0]          kp,
	input  logic [mcp_pkg::GAIN_W-1:0]          ki,
	input  logic [mcp_pkg::GAIN_W-1:0]          kd,
	input  logic [mcp_pkg::LIM_W-1:0]           ilim,
	input  logic [mcp_pkg::LIM_W-1:0]           olim,
	input  logic [mcp_pkg::PER_W-1:0]           period,
	output logic                                rem_lt,
	output logic [mcp_pkg::Q_W-1:0]             pulse_width,
	output logic                                direction_negative,
	output logic                                output_saturated
);
	import mcp_pkg::*;

	logic signed [ERR_W-1:0]  err_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic signed [ERR_W-1:0]  prev_q;
	logic signed [DIFF_W-1:0] diff_q;
	logic signed [FF_W-1:0]   ff_q;
	logic                     dir_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic                     sat_q;
	logic [LIM_W-1:0]         mag_q;
	logic [X_W-1:0]           x_q;
	logic [Q_W-1:0]           q_q;
	logic [R_W-1:0]           r_q;
	logic signed [PROD_W-1:0] prod_q;

	logic [MA_W-1:0]          ma;
	logic signed [MB_W-1:0]   mb;
	logic signed [PROD_W-1:0] prod;

	logic signed [SUM_W:0]    sum_ext;
	logic signed [SUM_W-1:0]  sum_sat;
	logic signed [PROD_W-1:0] ilim_p;
	logic signed [ACC_W-1:0]  iterm;
	logic signed [ACC_W-1:0]  olim_a;
	logic signed [ACC_W-1:0]  uclamp;
	logic                     uhit;
	logic signed [ACC_W-1:0]  absv;
	logic [LIM_W-1:0]         mag_d;
	logic [X_W-1:0]           rem_full;
	logic signed [FF_W-1:0]   ff_in;

	always_comb begin
		unique case (ctl.mul)
			MUL_KP_ERR: begin
				ma = {{(MA_W-GAIN_W){1'b0}}, kp};
				mb = {{(MB_W-ERR_W){err_q[ERR_W-1]}}, err_q};
			end
			MUL_KI_SUM: begin
				ma = {{(MA_W-GAIN_W){1'b0}}, ki};
				mb = {{(MB_W-SUM_W){sum_q[SUM_W-1]}}, sum_q};
			end
			MUL_KD_DIFF: begin
				ma = {{(MA_W-GAIN_W){1'b0}}, kd};
				mb = {{(MB_W-DIFF_W){diff_q[DIFF_W-1]}}, diff_q};
			end
			MUL_MAG_PER: begin
				ma = {{(MA_W-LIM_W){1'b0}}, mag_q};
				mb = {{(MB_W-PER_W){1'b0}}, period};
			end
			MUL_RCP_X: begin
				ma = {1'b0, RECIP_100};
				mb = {{(MB_W-X_W){1'b0}}, x_q};
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	assign prod = $signed({1'b0, ma}) * mb;

	// saturating integral
	assign sum_ext = {sum_q[SUM_W-1], sum_q} + {{(SUM_W+1-ERR_W){err_q[ERR_W-1]}}, err_q};
	always_comb begin
		priority if (sum_ext[SUM_W] != sum_ext[SUM_W-1])
			sum_sat = sum_ext[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
		else
			sum_sat = sum_ext[SUM_W-1:0];
	end

	assign ilim_p = $signed({{(PROD_W-LIM_W){1'b0}}, ilim});
	always_comb begin
		priority if (prod_q > ilim_p)
			iterm = $signed({{(ACC_W-LIM_W){1'b0}}, ilim});
		else if (prod_q < -ilim_p)
			iterm = -$signed({{(ACC_W-LIM_W){1'b0}}, ilim});
		else
			iterm = prod_q[ACC_W-1:0];
	end

	assign olim_a = $signed({{(ACC_W-LIM_W){1'b0}}, olim});
	always_comb begin
		uhit = 1'b1;
		priority if (acc_q > olim_a)
			uclamp = olim_a;
		else if (acc_q < -olim_a)
			uclamp = -olim_a;
		else begin
			uclamp = acc_q;
			uhit = 1'b0;
		end
	end

	assign absv  = acc_q[ACC_W-1] ? -acc_q : acc_q;
	assign mag_d = (absv > $signed({{(ACC_W-LIM_W){1'b0}}, FULL_DUTY})) ?
		FULL_DUTY : absv[LIM_W-1:0];

	assign rem_full = x_q - ({{(X_W-Q_W){1'b0}}, q_q} * DIVISOR);
	assign rem_lt   = r_q < R_W'(DIVISOR);

	assign ff_in = {feedforward[23], feedforward};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q  <= '0;
			prev_q <= '0;
		end else if (ctl.en && ctl.op == OP_INTEG) begin
			sum_q  <= sum_sat;
			prev_q <= err_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en && ctl.mul != MUL_NONE) begin
			prod_q <= prod;
		end
		if (ctl.en) begin
			unique case (ctl.op)
				OP_LOAD: begin
					err_q <= {reference_ma[15], reference_ma} - {measured_ma[15], measured_ma};
					ff_q  <= accel_positive ? ff_in : -ff_in;
					dir_q <= !accel_positive;
				end
				OP_INTEG:      diff_q <= {err_q[ERR_W-1], err_q} - {prev_q[ERR_W-1], prev_q};
				OP_ACC_FF:     acc_q <= {{(ACC_W-FF_W){ff_q[FF_W-1]}}, ff_q};
				OP_ADD_PROD:   acc_q <= acc_q + prod_q[ACC_W-1:0];
				OP_ADD_ICLAMP: acc_q <= acc_q + iterm;
				OP_CLAMP_U: begin
					acc_q <= uclamp;
					sat_q <= uhit;
				end
				OP_MAG:        mag_q <= mag_d;
				OP_SHIFT:      x_q <= prod_q[X_W+15:16];
				OP_QUOT:       q_q <= prod_q[RECIP_SH+Q_W-1:RECIP_SH];
				OP_REM:        r_q <= rem_full[R_W-1:0];
				OP_INC:        q_q <= q_q + 1'b1;
				OP_EMIT: begin
					pulse_width        <= q_q;
					direction_negative <= dir_q;
					output_saturated   <= sat_q;
				end
				default: ;
			endcase
		end
	end

endmodule

/* src/motor_current_pid_pwm.sv */
// Top level of the motor current PID controller with PWM pulse output.
// Holds the configuration registers and the result handshake.
// Depends on mcp_pkg, mcp_sequencer and mcp_datapath.
//
//   channel | handshake              | payload
//   --------+------------------------+-------------------------------------------
//   in      | in_valid / in_ready    | reference_ma, measured_ma, accel_positive,
//           |                        | feedforward
//   out     | out_valid / out_ready  | pulse_width, direction_negative,
//           |                        | output_saturated
//   cfg     | cfg_write (no wait)    | cfg_index, cfg_data
//
// An item runs through a 16-step microprogram around one shared 29x33 multiplier,
// with the divide-by-100 correction step skipped when not needed.
// in_ready is high only on step 0; the result register frees the sequencer, so
// the next item may start while a result waits. A full result register holds
// the last step. Reset clears the integral, the previous error and the step.
module motor_current_pid_pwm (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic signed [15:0]             reference_ma,
	input  logic signed [15:0]             measured_ma,
	input  logic                           accel_positive,
	input  logic signed [23:0]             feedforward,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [19:0]                    pulse_width,
	output logic                           direction_negative,
	output logic                           output_saturated,
	input  logic                           cfg_write,
	input  logic [mcp_pkg::CIDX_W-1:0]     cfg_index,
	input  logic [mcp_pkg::CDATA_W-1:0]    cfg_data
);
	import mcp_pkg::*;

	logic [GAIN_W-1:0] kp_q;
	logic [GAIN_W-1:0] ki_q;
	logic [GAIN_W-1:0] kd_q;
	logic [LIM_W-1:0]  ilim_q;
	logic [LIM_W-1:0]  olim_q;
	logic [PER_W-1:0]  period_q;
	logic              out_valid_q;

	ctl_t      ctl;
	seq_stat_t stat;
	logic      rem_lt;
	logic      emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q     <= 24'd655;
			ki_q     <= 24'd655;
			kd_q     <= 24'd0;
			ilim_q   <= 23'd655360;
			olim_q   <= 23'd6553600;
			period_q <= 20'd50000;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_KP:     kp_q     <= cfg_data;
				REG_KI:     ki_q     <= cfg_data;
				REG_KD:     kd_q     <= cfg_data;
				REG_ILIMIT: ilim_q   <= cfg_data[LIM_W-1:0];
				REG_OLIMIT: olim_q   <= cfg_data[LIM_W-1:0];
				REG_PERIOD: period_q <= cfg_data[PER_W-1:0];
				default: ;
			endcase
		end
	end

	assign stat = '{in_valid: in_valid, out_busy: out_valid_q && !out_ready, rem_lt: rem_lt};
	assign in_ready = (ctl.op == OP_LOAD);
	assign emit     = ctl.en && (ctl.op == OP_EMIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	mcp_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctl    (ctl)
	);

	mcp_datapath u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.ctl                (ctl),
		.reference_ma       (reference_ma),
		.measured_ma        (measured_ma),
		.accel_positive     (accel_positive),
		.feedforward        (feedforward),
		.kp                 (kp_q),
		.ki                 (ki_q),
		.kd                 (kd_q),
		.ilim               (ilim_q),
		.olim               (olim_q),
		.period             (period_q),
		.rem_lt             (rem_lt),
		.pulse_width        (pulse_width),
		.direction_negative (direction_negative),
		.output_saturated   (output_saturated)
	);

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("sequencer ready right after taking an item");

	a_emit_only_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> (!out_valid_q || out_ready))
		else $error("result overwritten before it was taken");

	a_pulse_in_period: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pulse_width <= period_q))
		else $error("pulse width above period");

	a_no_emit_while_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !emit)
		else $error("result emitted from idle step");
`endif

endmodule

/* tb/sv/tb_motor_current_pid_pwm.sv */
// Self-checking testbench for motor_current_pid_pwm: directed, random and soak items
// against a cycle-free predictor of the PID loop and the PWM pulse width.
// Depends on mcp_pkg and the motor_current_pid_pwm RTL.
`timescale 1ns / 1ps

module tb_motor_current_pid_pwm;
	import mcp_pkg::*;

	localparam int        LIMIT_CYCLES = 3000000;
	localparam int        MAX_REPORTS  = 200;
	localparam longint    FULL_SCALE   = 6553600;
	localparam logic [2:0] REG_SPARE_6 = 3'd6;
	localparam logic [2:0] REG_SPARE_7 = 3'd7;

	typedef struct packed {
		logic [19:0] pulse;
		logic        dir_neg;
		logic        sat;
	} pulse_result_t;

	class pid_pulse_tracker;
		logic [23:0]     kp = 655;
		logic [23:0]     ki = 655;
		logic [23:0]     kd = 0;
		logic [22:0]     ilim = 655360;
		logic [22:0]     olim = 6553600;
		logic [19:0]     period = 50000;
		longint          integral = 0;
		longint          last_err = 0;
		pulse_result_t   due_pulses[$];
		int              bad = 0;

		function void set_reg(logic [2:0] idx, logic [23:0] val);
			case (idx)
				REG_KP:     kp = val;
				REG_KI:     ki = val;
				REG_KD:     kd = val;
				REG_ILIMIT: ilim = val[22:0];
				REG_OLIMIT: olim = val[22:0];
				REG_PERIOD: period = val[19:0];
				default: ;
			endcase
		endfunction

		function void take_tick(logic signed [15:0] r, logic signed [15:0] m, logic pos,
				logic signed [23:0] ff);
			longint        e;
			longint        s;
			longint        it;
			longint        dt;
			longint        u;
			longint        mag;
			longint        lim;
			logic          hit;
			pulse_result_t res;
			e = longint'(r) - longint'(m);
			s = integral + e;
			if (s > 64'sd2147483647)
				s = 64'sd2147483647;
			if (s < -64'sd2147483648)
				s = -64'sd2147483648;
			integral = s;
			lim = longint'(ilim);
			it = longint'(ki) * s;
			if (it > lim)
				it = lim;
			else if (it < -lim)
				it = -lim;
			dt = longint'(kd) * (e - last_err);
			last_err = e;
			u = longint'(kp) * e + it + dt + (pos ? longint'(ff) : -longint'(ff));
			lim = longint'(olim);
			hit = 1'b0;
			if (u > lim) begin
				u = lim;
				hit = 1'b1;
			end else if (u < -lim) begin
				u = -lim;
				hit = 1'b1;
			end
			mag = (u < 0) ? -u : u;
			if (mag > FULL_SCALE)
				mag = FULL_SCALE;
			res.pulse = 20'((mag * longint'(period)) / FULL_SCALE);
			res.dir_neg = !pos;
			res.sat = hit;
			due_pulses.push_back(res);
		endfunction

		function void flag(string what, longint exp_v, longint act_v);
			bad++;
			if (bad <= MAX_REPORTS)
				$display("%0t: %s expected %0d actual %0d", $time, what, exp_v, act_v);
		endfunction

		function void match_pulse(logic [19:0] pw, logic dn, logic sat);
			pulse_result_t want;
			if (due_pulses.size() == 0) begin
				bad++;
				if (bad <= MAX_REPORTS)
					$display("%0t: unexpected item, expected none actual pulse_width %0d",
						$time, pw);
			end else begin
				want = due_pulses.pop_front();
				if (pw !== want.pulse)
					flag("pulse_width", want.pulse, pw);
				if (dn !== want.dir_neg)
					flag("direction_negative", want.dir_neg, dn);
				if (sat !== want.sat)
					flag("output_saturated", want.sat, sat);
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic signed [15:0] reference_ma;
	logic signed [15:0] measured_ma;
	logic               accel_positive;
	logic signed [23:0] feedforward;
	logic               out_valid;
	logic               out_ready;
	logic [19:0]        pulse_width;
	logic               direction_negative;
	logic               output_saturated;
	logic               cfg_write;
	logic [2:0]         cfg_index;
	logic [23:0]        cfg_data;

	pid_pulse_tracker   trk;
	logic               tx_calm;
	logic               rx_calm;
	logic               hold_req;
	int                 hold_left;
	int                 cycles;

	motor_current_pid_pwm dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_ready           (in_ready),
		.reference_ma       (reference_ma),
		.measured_ma        (measured_ma),
		.accel_positive     (accel_positive),
		.feedforward        (feedforward),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.pulse_width        (pulse_width),
		.direction_negative (direction_negative),
		.output_saturated   (output_saturated),
		.cfg_write          (cfg_write),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		cycles = 0;
		while (cycles < LIMIT_CYCLES) begin
			@(posedge clk);
			cycles++;
		end
		$display("Mismatches found");
		$finish;
	end

	// result side: random stalls, plus one long hold-off on request
	always @(negedge clk) begin
		if (hold_req) begin
			hold_req = 1'b0;
			hold_left = 400;
		end
		if (hold_left != 0) begin
			out_ready = 1'b0;
			hold_left--;
		end else
			out_ready = rx_calm || ($urandom_range(0, 99) >= 9);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			trk.match_pulse(pulse_width, direction_negative, output_saturated);
	end

	task automatic send_tick(input logic signed [15:0] r, input logic signed [15:0] m,
			input logic p, input logic signed [23:0] f);
		if (!tx_calm && $urandom_range(0, 99) < 9) begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat ($urandom_range(1, 20)) @(posedge clk);
		end
		@(negedge clk);
		in_valid = 1'b1;
		reference_ma = r;
		measured_ma = m;
		accel_positive = p;
		feedforward = f;
		do
			@(posedge clk);
		while (!in_ready);
		trk.take_tick(r, m, p, f);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		in_valid = 1'b0;
		while (trk.due_pulses.size() != 0)
			@(posedge clk);
		repeat (24) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
		@(negedge clk);
		cfg_write = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_write = 1'b0;
		trk.set_reg(idx, val);
	endtask

	function automatic logic [23:0] rand_gain();
		case ($urandom_range(0, 9))
			0: return 24'd0;
			1: return 24'hFFFFFF;
			2: return 24'($urandom);
			default: return 24'($urandom_range(0, 32768));
		endcase
	endfunction

	function automatic logic [23:0] rand_limit();
		case ($urandom_range(0, 7))
			0: return 24'd0;
			1: return 24'h7FFFFF;
			2: return 24'd6553600;
			3: return {1'b0, 23'($urandom)};
			default: return 24'($urandom_range(0, 6553600));
		endcase
	endfunction

	function automatic logic [23:0] rand_period();
		case ($urandom_range(0, 7))
			0: return 24'd0;
			1: return 24'd1;
			2: return 24'hFFFFF;
			3: return {4'd0, 20'($urandom)};
			default: return 24'($urandom_range(1000, 1000000));
		endcase
	endfunction

	task automatic random_tick();
		logic signed [15:0] r;
		logic signed [15:0] m;
		logic               p;
		logic signed [23:0] f;
		p = 1'($urandom);
		case ($urandom_range(0, 9))
			6, 7: begin
				r = 16'($urandom);
				m = 16'($urandom);
				f = 24'($urandom);
			end
			8: begin
				r = ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
				m = ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
				f = 24'($urandom_range(0, 13107200) - 6553600);
			end
			9: begin
				r = 16'($urandom_range(0, 2000) - 1000);
				m = 16'($urandom_range(0, 2000) - 1000);
				case ($urandom_range(0, 3))
					0: f = 24'sd6553600;
					1: f = -24'sd6553600;
					2: f = 24'sh7FFFFF;
					default: f = 24'sh800000;
				endcase
			end
			default: begin
				r = 16'($urandom_range(0, 8000) - 4000);
				m = 16'(r + $urandom_range(0, 200) - 100);
				f = 24'($urandom_range(0, 1310720) - 655360);
			end
		endcase
		send_tick(r, m, p, f);
	endtask

	initial begin
		int ph;
		int n;
		trk = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		reference_ma = '0;
		measured_ma = '0;
		accel_positive = 1'b0;
		feedforward = '0;
		out_ready = 1'b0;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		tx_calm = 1'b0;
		rx_calm = 1'b0;
		hold_req = 1'b0;
		hold_left = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings, input extremes, both directions
		send_tick(0, 0, 1'b1, 0);
		send_tick(16'sh7FFF, 16'sh8000, 1'b1, 24'sh7FFFFF);
		send_tick(16'sh8000, 16'sh7FFF, 1'b0, 24'sh800000);
		send_tick(100, 50, 1'b0, 24'sd6553600);
		send_tick(-100, 0, 1'b1, -24'sd6553600);
		wait_idle();

		// output exactly at the limit vs one past it; spare indexes ignored
		write_reg(REG_KP, 24'd65536);
		write_reg(REG_KI, 24'd0);
		write_reg(REG_KD, 24'd0);
		write_reg(REG_OLIMIT, 24'd655360);
		write_reg(REG_PERIOD, 24'd1000000);
		write_reg(REG_SPARE_6, 24'hFFFFFF);
		write_reg(REG_SPARE_7, 24'hFFFFFF);
		send_tick(10, 0, 1'b1, 0);
		send_tick(11, 0, 1'b1, 0);
		send_tick(0, 10, 1'b1, 0);
		send_tick(0, 11, 1'b1, 0);
		wait_idle();

		// maximum gains, limits above full duty, zero period, then full-scale period
		write_reg(REG_KP, 24'hFFFFFF);
		write_reg(REG_KI, 24'hFFFFFF);
		write_reg(REG_KD, 24'hFFFFFF);
		write_reg(REG_ILIMIT, 24'h7FFFFF);
		write_reg(REG_OLIMIT, 24'h7FFFFF);
		write_reg(REG_PERIOD, 24'd0);
		send_tick(16'sh7FFF, 16'sh8000, 1'b1, 0);
		send_tick(16'sh8000, 16'sh7FFF, 1'b0, 0);
		send_tick(0, 0, 1'b1, 0);
		wait_idle();
		write_reg(REG_PERIOD, 24'hFFFFF);
		send_tick(16'sh7FFF, 16'sh8000, 1'b1, 0);
		send_tick(5, 5, 1'b0, 0);
		wait_idle();

		// derivative only, zero integral clamp
		write_reg(REG_KP, 24'd0);
		write_reg(REG_KI, 24'd0);
		write_reg(REG_KD, 24'd13107200);
		write_reg(REG_ILIMIT, 24'd0);
		write_reg(REG_OLIMIT, 24'd6553600);
		write_reg(REG_PERIOD, 24'd50000);
		send_tick(5, 0, 1'b1, 0);
		send_tick(-5, 0, 1'b1, 0);
		send_tick(0, 0, 1'b0, 0);

		for (ph = 0; ph < 9; ph++) begin
			wait_idle();
			write_reg(REG_KP, rand_gain());
			write_reg(REG_KI, rand_gain());
			write_reg(REG_KD, rand_gain());
			write_reg(REG_ILIMIT, rand_limit());
			write_reg(REG_OLIMIT, rand_limit());
			write_reg(REG_PERIOD, rand_period());
			tx_calm = (ph == 4);
			rx_calm = (ph == 4);
			for (n = 0; n < 183; n++) begin
				if (ph == 2 && n == 20)
					hold_req = 1'b1;
				if (ph == 6 && n == 90)
					wait_idle();
				random_tick();
			end
		end
		wait_idle();

		// push the integral hard upward, then back down, at full rate
		write_reg(REG_KP, 24'd655);
		write_reg(REG_KI, 24'd1);
		write_reg(REG_KD, 24'd0);
		write_reg(REG_ILIMIT, 24'h7FFFFF);
		write_reg(REG_OLIMIT, 24'h7FFFFF);
		write_reg(REG_PERIOD, 24'hFFFFF);
		tx_calm = 1'b1;
		rx_calm = 1'b1;
		for (n = 0; n < 24; n++)
			send_tick(16'sh7FFF, 16'sh8000, 1'($urandom), 24'($urandom));
		for (n = 0; n < 3; n++)
			send_tick(16'sh7FFF, 16'sh8000, 1'b1, 0);
		for (n = 0; n < 3; n++)
			send_tick(16'sh8000, 16'sh7FFF, 1'b0, 0);
		send_tick(0, 0, 1'b1, 0);

		wait_idle();
		if (trk.bad == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
